@@ rtl/next_lexicographic_permutation_macros.svh @@
// Assertion macros for the next-permutation block.
// Included by the top level; synthesis builds see empty macro bodies.
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_MACROS_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define NLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nlp assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define NLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nlp assertion failed");
`else
`define NLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define NLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/nlp_pkg.sv @@
// Shared constants and types for the next-permutation block.
// Used by nlp_front, nlp_back and the top level; no dependencies.
package nlp_pkg;

    // Default sizes of the sequence store.
    localparam int MAX_LEN_DEF     = 8;
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed field widths on the ports.
    localparam int FIELD_INDEX_W = 3;
    localparam int FIELD_VALUE_W = 16;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 24;
    localparam int CFG_LEN_W     = 4;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ACTIVE_LENGTH = 1'b0;

    // Operation codes of an input word.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic idle;
        logic finding;
        logic find_ok;
        logic reversing;
        logic rev_ok;
    } t_back_status;

endpackage

@@ rtl/next_lexicographic_permutation.sv @@
// Next lexicographic permutation engine: a store of MAX_LEN values of which
// the first active_length take part. A write word (tuser 0) stores one value
// and returns nothing; a step word (tuser 1) turns the active part into its
// next permutation in lexicographic order (repeated values as a multiset)
// and returns every active element in order, tlast on the last one and tuser
// set when a next permutation existed. The store has one read and one write
// port, so a step makes one store access per cycle while the output is not
// stalled: it scans left to the rightmost ascent, searches from the right
// for the swap partner, swaps, reverses the suffix pair by pair and emits
// the active elements; a step with no next permutation scans and emits.
// A two-word queue lets input words be taken while a step is still running.
// Store entries read before they are written return unspecified values.
`include "next_lexicographic_permutation_macros.svh"
module next_lexicographic_permutation #(
    parameter int MAX_LEN     = nlp_pkg::MAX_LEN_DEF,
    parameter int VALUE_WIDTH = nlp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: write_index [2:0], write_value [18:3], zero [23:19]
    input  logic [nlp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: operation [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: element_index [2:0], element_value [18:3], zero [23:19]
    output logic [nlp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: advanced [0]
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nlp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [nlp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [nlp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam logic [nlp_pkg::CFG_LEN_W-1:0] LEN_RESET =
        nlp_pkg::CFG_LEN_W'((MAX_LEN > 15) ? 15 : MAX_LEN);

    logic [nlp_pkg::CFG_LEN_W-1:0] r_active_length;
    logic [LW-1:0]                 eff_len;
    logic                          reg_sel;
    logic                          cfg_write;

    logic                   q_valid;
    logic                   q_op;
    logic [IW-1:0]          q_index;
    logic [VALUE_WIDTH-1:0] q_value;
    logic                   q_pop;

    logic [nlp_pkg::FIELD_INDEX_W-1:0] out_index;
    logic [nlp_pkg::FIELD_VALUE_W-1:0] out_value;
    nlp_pkg::t_back_status             back_status;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == nlp_pkg::REG_ACTIVE_LENGTH);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? nlp_pkg::APB_DATA_W'(r_active_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= LEN_RESET;
        end else if (cfg_write) begin
            r_active_length <= pwdata[nlp_pkg::CFG_LEN_W-1:0];
        end
    end

    // A length of zero acts as one; a length above the store acts as its size.
    always_comb begin
        if (r_active_length == '0) begin
            eff_len = LW'(1);
        end else if (32'(r_active_length) > MAX_LEN) begin
            eff_len = LW'(MAX_LEN);
        end else begin
            eff_len = LW'(r_active_length);
        end
    end

    nlp_front #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_index     (s_axis_tdata[2:0]),
        .i_value     (s_axis_tdata[18:3]),
        .o_cmd_valid (q_valid),
        .o_cmd_op    (q_op),
        .o_cmd_index (q_index),
        .o_cmd_value (q_value),
        .i_cmd_pop   (q_pop)
    );

    nlp_back #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_len       (eff_len),
        .i_cmd_valid (q_valid),
        .i_cmd_op    (q_op),
        .i_cmd_index (q_index),
        .i_cmd_value (q_value),
        .o_cmd_pop   (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_index     (out_index),
        .o_value     (out_value),
        .o_advanced  (m_axis_tuser),
        .o_last      (m_axis_tlast),
        .o_status    (back_status)
    );

    assign m_axis_tdata = {5'b0, out_value, out_index};

    // The back end takes a queued word only in its idle state.
    `NLP_ASSERT_IMPLY(a_pop_when_idle, i_clk, i_rst_n, q_pop, back_status.idle)
    `NLP_ASSERT_NEXT(a_step_starts, i_clk, i_rst_n, q_pop && q_op == nlp_pkg::OP_STEP, !back_status.idle)
    // The partner search never runs onto the pivot.
    `NLP_ASSERT_IMPLY(a_find_bound, i_clk, i_rst_n, back_status.finding, back_status.find_ok)
    `NLP_ASSERT_IMPLY(a_rev_bound, i_clk, i_rst_n, back_status.reversing, back_status.rev_ok)

endmodule

@@ rtl/nlp_front.sv @@
// Front end: accepts input words, drops writes outside the store and
// queues the rest for the back end. Depends on nlp_pkg.
module nlp_front #(
    parameter int MAX_LEN     = nlp_pkg::MAX_LEN_DEF,
    parameter int VALUE_WIDTH = nlp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic [nlp_pkg::FIELD_INDEX_W-1:0]   i_index,
    input  logic [nlp_pkg::FIELD_VALUE_W-1:0]   i_value,
    output logic                                o_cmd_valid,
    output logic                                o_cmd_op,
    output logic [$clog2(MAX_LEN)-1:0]          o_cmd_index,
    output logic [VALUE_WIDTH-1:0]              o_cmd_value,
    input  logic                                i_cmd_pop
);

    localparam int IW = $clog2(MAX_LEN);
    localparam int QD = nlp_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);

    logic                   r_q_op    [QD];
    logic [IW-1:0]          r_q_index [QD];
    logic [VALUE_WIDTH-1:0] r_q_value [QD];
    logic [PW-1:0]          r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]          r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]          r_count, n_count;
    logic                   keep;
    logic                   push;
    logic                   pop;

    // A write beyond the store is accepted and dropped here.
    assign keep    = (i_op == nlp_pkg::OP_STEP) || (32'(i_index) < 32'(MAX_LEN));
    assign o_ready = (r_count != CW'(QD));
    assign push    = i_valid && o_ready && keep;
    assign pop     = i_cmd_pop && o_cmd_valid;

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd_op    = r_q_op[r_rd_ptr];
    assign o_cmd_index = r_q_index[r_rd_ptr];
    assign o_cmd_value = r_q_value[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (32'(r_wr_ptr) == QD - 1) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == QD - 1) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_op[r_wr_ptr]    <= i_op;
            r_q_index[r_wr_ptr] <= IW'(i_index);
            r_q_value[r_wr_ptr] <= VALUE_WIDTH'(i_value);
        end
    end

endmodule

@@ rtl/nlp_back.sv @@
// Back end: holds the sequence store, runs the permutation step one store
// access per cycle and emits the elements. Depends on nlp_pkg.
module nlp_back #(
    parameter int MAX_LEN     = nlp_pkg::MAX_LEN_DEF,
    parameter int VALUE_WIDTH = nlp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(MAX_LEN+1)-1:0]        i_len,
    input  logic                                i_cmd_valid,
    input  logic                                i_cmd_op,
    input  logic [$clog2(MAX_LEN)-1:0]          i_cmd_index,
    input  logic [VALUE_WIDTH-1:0]              i_cmd_value,
    output logic                                o_cmd_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [nlp_pkg::FIELD_INDEX_W-1:0]   o_index,
    output logic [nlp_pkg::FIELD_VALUE_W-1:0]   o_value,
    output logic                                o_advanced,
    output logic                                o_last,
    output nlp_pkg::t_back_status               o_status
);

    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FIRST = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_FIND  = 4'd3;
    localparam logic [3:0] ST_SWAP  = 4'd4;
    localparam logic [3:0] ST_REVA  = 4'd5;
    localparam logic [3:0] ST_REVB  = 4'd6;
    localparam logic [3:0] ST_REVC  = 4'd7;
    localparam logic [3:0] ST_EMRD  = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    logic [VALUE_WIDTH-1:0] r_mem [MAX_LEN];
    logic [VALUE_WIDTH-1:0] r_rdata;

    logic [3:0]             r_state, n_state;
    logic [LW-1:0]          r_len, n_len;
    logic [IW-1:0]          r_idx, n_idx;
    logic [IW-1:0]          r_lo, n_lo;
    logic [IW-1:0]          r_hi, n_hi;
    logic [IW-1:0]          r_k, n_k;
    logic [VALUE_WIDTH-1:0] r_prev, n_prev;
    logic [VALUE_WIDTH-1:0] r_pval, n_pval;
    logic [VALUE_WIDTH-1:0] r_tval, n_tval;
    logic                   r_adv, n_adv;

    logic                              r_ovalid, n_ovalid;
    logic [nlp_pkg::FIELD_INDEX_W-1:0] r_oindex, n_oindex;
    logic [nlp_pkg::FIELD_VALUE_W-1:0] r_ovalue, n_ovalue;
    logic                              r_oadv, n_oadv;
    logic                              r_olast, n_olast;

    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [IW-1:0]          len_m1;
    logic                   out_free;

    assign len_m1   = IW'(r_len - LW'(1));
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_idx    = r_idx;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_k      = r_k;
        n_prev   = r_prev;
        n_pval   = r_pval;
        n_tval   = r_tval;
        n_adv    = r_adv;
        n_ovalid = r_ovalid;
        n_oindex = r_oindex;
        n_ovalue = r_ovalue;
        n_oadv   = r_oadv;
        n_olast  = r_olast;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        o_cmd_pop = 1'b0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd_op == nlp_pkg::OP_WRITE) begin
                        wr_en   = 1'b1;
                        wr_addr = i_cmd_index;
                        wr_data = i_cmd_value;
                    end else begin
                        n_len = i_len;
                        n_adv = 1'b0;
                        if (32'(i_len) < 2) begin
                            n_state = ST_EMRD;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = IW'(i_len - LW'(1));
                            n_idx   = IW'(i_len - LW'(1));
                            n_state = ST_FIRST;
                        end
                    end
                end
            end
            ST_FIRST: begin
                n_prev  = r_rdata;
                rd_en   = 1'b1;
                rd_addr = r_idx - IW'(1);
                n_idx   = r_idx - IW'(1);
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // Walk left until an element is smaller than its right neighbor.
                if (r_rdata < r_prev) begin
                    n_pval  = r_rdata;
                    rd_en   = 1'b1;
                    rd_addr = len_m1;
                    n_hi    = len_m1;
                    n_state = ST_FIND;
                end else if (r_idx == '0) begin
                    n_state = ST_EMRD;
                end else begin
                    n_prev  = r_rdata;
                    rd_en   = 1'b1;
                    rd_addr = r_idx - IW'(1);
                    n_idx   = r_idx - IW'(1);
                end
            end
            ST_FIND: begin
                // The suffix is non-increasing, so the first larger value seen
                // from the right is the rightmost one.
                if (r_rdata > r_pval) begin
                    wr_en   = 1'b1;
                    wr_addr = r_hi;
                    wr_data = r_pval;
                    n_tval  = r_rdata;
                    n_state = ST_SWAP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_hi - IW'(1);
                    n_hi    = r_hi - IW'(1);
                end
            end
            ST_SWAP: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_tval;
                n_adv   = 1'b1;
                n_lo    = r_idx + IW'(1);
                n_hi    = len_m1;
                if (len_m1 > r_idx + IW'(1)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IW'(1);
                    n_state = ST_REVA;
                end else begin
                    n_state = ST_EMRD;
                end
            end
            ST_REVA: begin
                n_tval  = r_rdata;
                rd_en   = 1'b1;
                rd_addr = r_hi;
                n_state = ST_REVB;
            end
            ST_REVB: begin
                wr_en   = 1'b1;
                wr_addr = r_lo;
                wr_data = r_rdata;
                n_state = ST_REVC;
            end
            ST_REVC: begin
                wr_en   = 1'b1;
                wr_addr = r_hi;
                wr_data = r_tval;
                n_lo    = r_lo + IW'(1);
                n_hi    = r_hi - IW'(1);
                if (r_hi - IW'(1) > r_lo + IW'(1)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_lo + IW'(1);
                    n_state = ST_REVA;
                end else begin
                    n_state = ST_EMRD;
                end
            end
            ST_EMRD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_k     = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // The read data register holds while the output stage is full.
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oindex = nlp_pkg::FIELD_INDEX_W'(r_k);
                    n_ovalue = nlp_pkg::FIELD_VALUE_W'(r_rdata);
                    n_oadv   = r_adv;
                    n_olast  = (r_k == len_m1);
                    if (r_k == len_m1) begin
                        n_state = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_k + IW'(1);
                        n_k     = r_k + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_idx    <= n_idx;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_k      <= n_k;
        r_prev   <= n_prev;
        r_pval   <= n_pval;
        r_tval   <= n_tval;
        r_adv    <= n_adv;
        r_oindex <= n_oindex;
        r_ovalue <= n_ovalue;
        r_oadv   <= n_oadv;
        r_olast  <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_valid    = r_ovalid;
    assign o_index    = r_oindex;
    assign o_value    = r_ovalue;
    assign o_advanced = r_oadv;
    assign o_last     = r_olast;

    assign o_status.idle      = (r_state == ST_IDLE);
    assign o_status.finding   = (r_state == ST_FIND);
    assign o_status.find_ok   = (r_hi > r_idx);
    assign o_status.reversing = (r_state == ST_REVA) || (r_state == ST_REVB) ||
                                (r_state == ST_REVC);
    assign o_status.rev_ok    = (r_lo < r_hi);

endmodule
